// ===== src/circle_trace_point_generator_assert.svh =====
// Assertion macros used by the root engine of the circle trace point generator RTL.
// Each macro samples on the rising edge of clock and is disabled during reset.
`ifndef CIRCLE_TRACE_POINT_GENERATOR_ASSERT_SVH
`define CIRCLE_TRACE_POINT_GENERATOR_ASSERT_SVH

// cond holds at every edge
`define CTPG_ASSERT_HOLDS(label, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond)) else $error(msg);

// ante at an edge is followed by cons at the next edge
`define CTPG_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== src/ctpg_pkg.sv =====
// ----------------------------------------------------------------------------
// ctpg_pkg
// Shared constants and helpers for the circle trace point generator.
// ----------------------------------------------------------------------------
package ctpg_pkg;

   localparam int CENTER_W        = 12;
   localparam int OUT_W           = 14;
   localparam int RADIUS_BITS_DEF = 10;
   localparam int QUEUE_DEPTH     = 2;
   localparam int CSR_INDEX_W     = 2;

   // register indexes on the configuration port
   localparam logic [CSR_INDEX_W-1:0] CSR_CENTER_X = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_CENTER_Y = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_RADIUS   = 2'd2;

   function automatic int max_int(input int a, input int b);
      return (a > b) ? a : b;
   endfunction

endpackage

// ===== src/ctpg_front.sv =====
// ----------------------------------------------------------------------------
// ctpg_front
// Takes step transactions, advances the trace offset and direction, and
// pushes the new offset with its half-circle flag into the work queue.
// ----------------------------------------------------------------------------
module ctpg_front #(
   parameter int RADIUS_BITS = 10
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic [RADIUS_BITS-1:0] radius,
   input  logic                   req_push,
   output logic                   req_full,
   input  logic                   req_restart,
   output logic                   q_push,
   output logic [RADIUS_BITS+1:0] q_wdata,
   input  logic                   q_full
);

   localparam int RB = RADIUS_BITS;

   logic signed [RB:0]   offset_ff;
   logic signed [RB:0]   offset_in;
   logic                 up_ff;
   logic                 up_in;
   logic signed [RB:0]   d_sel;
   logic signed [RB+1:0] d_ext;
   logic signed [RB+1:0] r_ext;
   logic                 up_new;
   logic signed [RB:0]   d_new;

   assign req_full = q_full;
   assign q_push   = req_push & ~q_full;

   assign d_sel = req_restart ? -$signed({1'b0, radius}) : offset_ff;
   assign d_ext = (RB+2)'(d_sel);
   assign r_ext = $signed({2'b00, radius});

   // upper bound test wins when both bounds are met
   always_comb begin
      up_new = up_ff;
      if (d_ext <= -r_ext) begin
         up_new = 1'b1;
      end
      if (d_ext >= r_ext) begin
         up_new = 1'b0;
      end
   end

   assign d_new   = up_new ? d_sel + (RB+1)'(1) : d_sel - (RB+1)'(1);
   assign q_wdata = {up_new, d_new};

   assign offset_in = q_push ? d_new : offset_ff;
   assign up_in     = q_push ? up_new : up_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         offset_ff <= '1;
         up_ff     <= 1'b1;
      end else begin
         offset_ff <= offset_in;
         up_ff     <= up_in;
      end
   end

endmodule

// ===== src/ctpg_queue.sv =====
// ----------------------------------------------------------------------------
// ctpg_queue
// Short register queue between the step front end and the root engine.
// ----------------------------------------------------------------------------
module ctpg_queue
   import ctpg_pkg::*;
#(
   parameter int WIDTH = 12
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] wdata,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] rdata,
   output logic             empty
);

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   logic [WIDTH-1:0] entry_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff;
   logic [PTR_W-1:0] wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff;
   logic [PTR_W-1:0] rd_ptr_in;
   logic [CNT_W-1:0] count_ff;
   logic [CNT_W-1:0] count_in;
   logic             do_push;
   logic             do_pop;

   assign full    = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = push & ~full;
   assign do_pop  = pop & ~empty;
   assign rdata   = entry_ff[rd_ptr_ff];

   assign wr_ptr_in = ~do_push ? wr_ptr_ff :
                      (wr_ptr_ff == PTR_W'(QUEUE_DEPTH-1)) ? '0 : wr_ptr_ff + PTR_W'(1);
   assign rd_ptr_in = ~do_pop ? rd_ptr_ff :
                      (rd_ptr_ff == PTR_W'(QUEUE_DEPTH-1)) ? '0 : rd_ptr_ff + PTR_W'(1);

   always_comb begin
      count_in = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// ===== src/ctpg_back.sv =====
// ----------------------------------------------------------------------------
// ctpg_back
// Root engine: squares radius and offset, takes a bit-serial integer square
// root of the difference, forms the traced point and holds it for the reader.
// ----------------------------------------------------------------------------
`include "circle_trace_point_generator_assert.svh"

module ctpg_back
   import ctpg_pkg::*;
#(
   parameter int RADIUS_BITS = 10
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic [CENTER_W-1:0]     center_x,
   input  logic [CENTER_W-1:0]     center_y,
   input  logic [RADIUS_BITS-1:0]  radius,
   input  logic [RADIUS_BITS+1:0]  q_rdata,
   input  logic                    q_empty,
   output logic                    q_pop,
   output logic                    rsp_empty,
   input  logic                    rsp_pop,
   output logic signed [OUT_W-1:0] rsp_point_x,
   output logic signed [OUT_W-1:0] rsp_point_y
);

   localparam int RB = RADIUS_BITS;
   localparam int VW = 2 * RB;
   localparam int DW = 2 * RB + 2;
   localparam int RW = RB + 2;
   localparam int IW = $clog2(RB);
   localparam int XW = max_int(CENTER_W, RB + 1) + 2;
   localparam int YW = max_int(CENTER_W, RB) + 2;

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_MUL  = 3'd1;
   localparam logic [2:0] ST_SUB  = 3'd2;
   localparam logic [2:0] ST_ITER = 3'd3;
   localparam logic [2:0] ST_DONE = 3'd4;

   logic [2:0]              state_ff, state_in;
   logic signed [RB:0]      d_ff, d_in;
   logic                    up_ff, up_in;
   logic [VW-1:0]           rr_ff, rr_in;
   logic [DW-1:0]           dd_ff, dd_in;
   logic [VW-1:0]           v_ff, v_in;
   logic [RW-1:0]           rem_ff, rem_in;
   logic [RB-1:0]           root_ff, root_in;
   logic [IW-1:0]           iter_ff, iter_in;
   logic                    out_valid_ff, out_valid_in;
   logic signed [OUT_W-1:0] x_ff, x_in;
   logic signed [OUT_W-1:0] y_ff, y_in;

   logic [RB:0]             abs_d;
   logic [RW-1:0]           rem_shift;
   logic [RW-1:0]           trial;
   logic                    exact;
   logic signed [XW-1:0]    x_full;
   logic signed [YW-1:0]    cy_ext;
   logic signed [YW-1:0]    s_ext;
   logic signed [YW-1:0]    y_full;

   assign abs_d     = d_ff[RB] ? (RB+1)'(-d_ff) : (RB+1)'(d_ff);
   assign rem_shift = {rem_ff[RB-1:0], v_ff[VW-1 -: 2]};
   assign trial     = {root_ff, 2'b01};
   assign exact     = (rem_ff == '0);

   assign x_full = $signed(XW'({1'b0, center_x})) + XW'(d_ff);
   assign cy_ext = $signed(YW'({1'b0, center_y}));
   assign s_ext  = $signed(YW'({1'b0, root_ff}));

   // lower half: truncate toward zero, so step one further down unless exact
   // or the real result is not above zero
   always_comb begin
      if (up_ff) begin
         y_full = cy_ext + s_ext;
      end else if (exact || (cy_ext <= s_ext)) begin
         y_full = cy_ext - s_ext;
      end else begin
         y_full = cy_ext - s_ext - YW'(1);
      end
   end

   always_comb begin
      state_in     = state_ff;
      d_in         = d_ff;
      up_in        = up_ff;
      rr_in        = rr_ff;
      dd_in        = dd_ff;
      v_in         = v_ff;
      rem_in       = rem_ff;
      root_in      = root_ff;
      iter_in      = iter_ff;
      out_valid_in = out_valid_ff & ~rsp_pop;
      x_in         = x_ff;
      y_in         = y_ff;
      q_pop        = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (!q_empty) begin
               q_pop    = 1'b1;
               d_in     = $signed(q_rdata[RB:0]);
               up_in    = q_rdata[RB+1];
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            rr_in    = VW'(radius * radius);
            dd_in    = DW'(abs_d * abs_d);
            state_in = ST_SUB;
         end
         ST_SUB: begin
            // saturate to zero outside the circle
            v_in     = ({2'b00, rr_ff} > dd_ff) ? VW'({2'b00, rr_ff} - dd_ff) : '0;
            rem_in   = '0;
            root_in  = '0;
            iter_in  = '0;
            state_in = ST_ITER;
         end
         ST_ITER: begin
            if (rem_shift >= trial) begin
               rem_in  = rem_shift - trial;
               root_in = {root_ff[RB-2:0], 1'b1};
            end else begin
               rem_in  = rem_shift;
               root_in = {root_ff[RB-2:0], 1'b0};
            end
            v_in    = {v_ff[VW-3:0], 2'b00};
            iter_in = iter_ff + IW'(1);
            if (iter_ff == IW'(RB - 1)) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            // hold until the output register is free
            if (!out_valid_ff || rsp_pop) begin
               out_valid_in = 1'b1;
               x_in         = x_full[OUT_W-1:0];
               y_in         = y_full[OUT_W-1:0];
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      d_ff    <= d_in;
      up_ff   <= up_in;
      rr_ff   <= rr_in;
      dd_ff   <= dd_in;
      v_ff    <= v_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
      iter_ff <= iter_in;
      x_ff    <= x_in;
      y_ff    <= y_in;
   end

   assign rsp_empty   = ~out_valid_ff;
   assign rsp_point_x = x_ff;
   assign rsp_point_y = y_ff;

   `CTPG_ASSERT_HOLDS(a_iter_bound, (state_ff != ST_ITER) || (iter_ff < IW'(RB - 1)) || (iter_ff == IW'(RB - 1)), "root iteration count out of range")
   `CTPG_ASSERT_NEXT(a_done_stall, (state_ff == ST_DONE) && out_valid_ff && !rsp_pop, state_ff == ST_DONE, "finished point dropped while output stalled")
   `CTPG_ASSERT_NEXT(a_valid_source, (state_ff != ST_DONE) && !out_valid_ff, !out_valid_ff, "result appeared without a finished root")

endmodule

// ===== src/circle_trace_point_generator.sv =====
// ----------------------------------------------------------------------------
// circle_trace_point_generator
// Traces a circle one point per transaction: x = cx + d, y = cy +/- isqrt.
//
// Usage:
//  - Input queue: raise req_push with req_restart while req_full is low; each
//    transaction steps the offset d by one (restart first returns it to -R).
//  - Result queue: while rsp_empty is low, rsp_point_x/rsp_point_y hold the
//    oldest point; raise rsp_pop to take it. Points come out in input order.
//  - Configuration: csr_wen writes csr_wdata to register csr_index at once
//    (center_x, center_y, radius). Write only while no point is in flight.
//  - Each step passes ST_IDLE (pop), ST_MUL (squares), ST_SUB (difference),
//    ST_ITER (bit-serial square root, one root bit per cycle) and ST_DONE; the
//    root unit takes no new step until the current point is in the output register.
//  - A two-entry queue lets steps be taken while the root unit is busy; when
//    the reader stalls, the finished point waits in the output register and
//    the queue fills, then req_full rises.
//  - Reset: centers 0, radius 1, offset -1, upper half first, both queues
//    empty. No clearing pass is needed.
// ----------------------------------------------------------------------------
module circle_trace_point_generator
   import ctpg_pkg::*;
#(
   parameter int RADIUS_BITS = RADIUS_BITS_DEF,
   localparam int CSR_W = max_int(CENTER_W, RADIUS_BITS)
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_push,
   output logic                    req_full,
   input  logic                    req_restart,
   output logic                    rsp_empty,
   input  logic                    rsp_pop,
   output logic signed [OUT_W-1:0] rsp_point_x,
   output logic signed [OUT_W-1:0] rsp_point_y,
   input  logic                    csr_wen,
   input  logic [CSR_INDEX_W-1:0]  csr_index,
   input  logic [CSR_W-1:0]        csr_wdata
);

   localparam int QW = RADIUS_BITS + 2;

   logic [CENTER_W-1:0]    center_x_ff, center_x_in;
   logic [CENTER_W-1:0]    center_y_ff, center_y_in;
   logic [RADIUS_BITS-1:0] radius_ff, radius_in;

   logic          q_push;
   logic [QW-1:0] q_wdata;
   logic          q_full;
   logic          q_pop;
   logic [QW-1:0] q_rdata;
   logic          q_empty;

   always_comb begin
      center_x_in = center_x_ff;
      center_y_in = center_y_ff;
      radius_in   = radius_ff;
      if (csr_wen) begin
         case (csr_index)
            CSR_CENTER_X: center_x_in = csr_wdata[CENTER_W-1:0];
            CSR_CENTER_Y: center_y_in = csr_wdata[CENTER_W-1:0];
            CSR_RADIUS:   radius_in   = csr_wdata[RADIUS_BITS-1:0];
            default:      ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         center_x_ff <= '0;
         center_y_ff <= '0;
         radius_ff   <= RADIUS_BITS'(1);
      end else begin
         center_x_ff <= center_x_in;
         center_y_ff <= center_y_in;
         radius_ff   <= radius_in;
      end
   end

   ctpg_front #(
      .RADIUS_BITS(RADIUS_BITS)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .radius      (radius_ff),
      .req_push    (req_push),
      .req_full    (req_full),
      .req_restart (req_restart),
      .q_push      (q_push),
      .q_wdata     (q_wdata),
      .q_full      (q_full)
   );

   ctpg_queue #(
      .WIDTH(QW)
   ) u_queue (
      .clock (clock),
      .reset (reset),
      .push  (q_push),
      .wdata (q_wdata),
      .full  (q_full),
      .pop   (q_pop),
      .rdata (q_rdata),
      .empty (q_empty)
   );

   ctpg_back #(
      .RADIUS_BITS(RADIUS_BITS)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .center_x    (center_x_ff),
      .center_y    (center_y_ff),
      .radius      (radius_ff),
      .q_rdata     (q_rdata),
      .q_empty     (q_empty),
      .q_pop       (q_pop),
      .rsp_empty   (rsp_empty),
      .rsp_pop     (rsp_pop),
      .rsp_point_x (rsp_point_x),
      .rsp_point_y (rsp_point_y)
   );

endmodule

// ===== verif/circle_trace_point_generator_test.sv =====
// ----------------------------------------------------------------------------
// circle_trace_point_generator_test
// Drives step transactions into the circle trace point generator and checks
// every point against an in-bench model of the trace: offset walk, half
// selection, exact truncated square root and 14-bit wrap of both coordinates.
// Directed cases cover reset state, coordinate extremes, a full lap, radius
// rewrites in mid-trace and zero radius; random traces follow under varying
// back-pressure on both queues.
// ----------------------------------------------------------------------------
module circle_trace_point_generator_test;
   import ctpg_pkg::*;

   localparam int CSR_DATA_W  = (CENTER_W > RADIUS_BITS_DEF) ? CENTER_W : RADIUS_BITS_DEF;
   localparam int RADIUS_MAX  = (1 << RADIUS_BITS_DEF) - 1;
   localparam int CENTER_MAX  = (1 << CENTER_W) - 1;
   localparam int SETTLE      = RADIUS_BITS_DEF + 5;
   localparam int CYCLE_LIMIT = 400000;
   localparam logic [CSR_INDEX_W-1:0] CSR_UNMAPPED = 2'd3;

   typedef struct packed {
      logic signed [OUT_W-1:0] x;
      logic signed [OUT_W-1:0] y;
   } point_type;

   logic                          clock;
   logic                          reset;
   logic                          req_push;
   logic                          req_full;
   logic                          req_restart;
   logic                          rsp_empty;
   logic                          rsp_pop;
   logic signed [OUT_W-1:0]       rsp_point_x;
   logic signed [OUT_W-1:0]       rsp_point_y;
   logic                          csr_wen;
   logic [CSR_INDEX_W-1:0]        csr_index;
   logic [CSR_DATA_W-1:0]         csr_wdata;

   // trace model state
   int  cfg_center_x = 0;
   int  cfg_center_y = 0;
   int  cfg_radius   = 1;
   int  trace_offset = -1;
   bit  trace_rising = 1'b1;

   point_type pending_points[$];
   int        error_count   = 0;
   int        cycle_count   = 0;
   int        send_idle_pct = 0;
   int        recv_idle_pct = 0;

   circle_trace_point_generator dut (
      .clock       (clock),
      .reset       (reset),
      .req_push    (req_push),
      .req_full    (req_full),
      .req_restart (req_restart),
      .rsp_empty   (rsp_empty),
      .rsp_pop     (rsp_pop),
      .rsp_point_x (rsp_point_x),
      .rsp_point_y (rsp_point_y),
      .csr_wen     (csr_wen),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   initial begin
      forever begin
         @(posedge clock);
         cycle_count++;
         if (cycle_count > CYCLE_LIMIT) begin
            $display("[circle_trace_point_generator] ERROR");
            $finish;
         end
      end
   end

   function automatic int floor_root(input int value);
      int root;
      int trial;
      root = 0;
      for (int b = RADIUS_BITS_DEF; b >= 0; b--) begin
         trial = root | (1 << b);
         if (trial * trial <= value) root = trial;
      end
      return root;
   endfunction

   // advance the trace by one step and form the point it lands on
   function automatic point_type step_trace(input logic restart);
      int        r;
      int        d;
      int        span;
      int        root;
      int        y;
      point_type p;
      r = cfg_radius;
      if (restart) trace_offset = -r;
      d = trace_offset;
      if (d <= -r) trace_rising = 1'b1;
      if (d >= r) trace_rising = 1'b0;
      d = trace_rising ? d + 1 : d - 1;
      trace_offset = d;
      span = (r * r > d * d) ? r * r - d * d : 0;
      root = floor_root(span);
      if (trace_rising) begin
         y = cfg_center_y + root;
      end else if (root * root == span || cfg_center_y <= root) begin
         y = cfg_center_y - root;
      end else begin
         // truncate toward zero: one below the floor when y is positive
         y = cfg_center_y - root - 1;
      end
      p.x = OUT_W'(cfg_center_x + d);
      p.y = OUT_W'(y);
      return p;
   endfunction

   task automatic send_step(input logic restart);
      while ($urandom_range(99) < send_idle_pct) begin
         req_push <= 1'b0;
         @(posedge clock);
      end
      req_push    <= 1'b1;
      req_restart <= restart;
      do @(posedge clock); while (req_full);
      pending_points.push_back(step_trace(restart));
   endtask

   // hold off the sender until every point in flight has been taken
   task automatic drain_points();
      req_push <= 1'b0;
      while (pending_points.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_register(input logic [CSR_INDEX_W-1:0] index,
                                 input logic [CSR_DATA_W-1:0] value);
      csr_wen   <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(posedge clock);
      case (index)
         CSR_CENTER_X: cfg_center_x = value[CENTER_W-1:0];
         CSR_CENTER_Y: cfg_center_y = value[CENTER_W-1:0];
         CSR_RADIUS:   cfg_radius   = value[RADIUS_BITS_DEF-1:0];
         default: ;
      endcase
      csr_wen <= 1'b0;
      @(posedge clock);
   endtask

   // result side: take points at random and compare with the oldest prediction
   initial begin
      point_type want;
      rsp_pop = 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_pop && !rsp_empty) begin
            if (pending_points.size() == 0) begin
               $error("point with no step pending: x %0d y %0d", rsp_point_x, rsp_point_y);
               error_count++;
            end else begin
               want = pending_points.pop_front();
               if (rsp_point_x !== want.x) begin
                  $error("point_x: expected %0d, got %0d", want.x, rsp_point_x);
                  error_count++;
               end
               if (rsp_point_y !== want.y) begin
                  $error("point_y: expected %0d, got %0d", want.y, rsp_point_y);
                  error_count++;
               end
            end
         end
         rsp_pop <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // reset values: radius one around the origin, negative coordinates wrap
   task automatic test_reset_trace();
      send_step(1'b0);
      send_step(1'b0);
      send_step(1'b0);
      send_step(1'b1);
      drain_points();
   endtask

   task automatic test_coordinate_extremes();
      write_register(CSR_CENTER_X, CSR_DATA_W'(CENTER_MAX));
      write_register(CSR_CENTER_Y, CSR_DATA_W'(CENTER_MAX));
      write_register(CSR_RADIUS, CSR_DATA_W'(RADIUS_MAX));
      send_step(1'b1);
      send_step(1'b0);
      send_step(1'b0);
      drain_points();
   endtask

   // both halves of a small circle, low center so the lower half goes negative
   task automatic test_full_lap();
      write_register(CSR_CENTER_X, CSR_DATA_W'(100));
      write_register(CSR_CENTER_Y, CSR_DATA_W'(1));
      write_register(CSR_RADIUS, CSR_DATA_W'(2));
      send_step(1'b1);
      repeat (8) send_step(1'b0);
      drain_points();
   endtask

   // grow the radius and restart the trace, then drop it to zero under the running trace
   task automatic test_radius_rewrite();
      write_register(CSR_RADIUS, CSR_DATA_W'(3));
      send_step(1'b1);
      repeat (3) send_step(1'b0);
      drain_points();
      // upper bits lie outside the radius register and must be dropped
      write_register(CSR_RADIUS, {2'b11, {(CSR_DATA_W-2){1'b0}}});
      repeat (3) send_step(1'b0);
      drain_points();
   endtask

   task automatic test_unmapped_index();
      write_register(CSR_UNMAPPED, {CSR_DATA_W{1'b1}});
      send_step(1'b0);
      drain_points();
   endtask

   function automatic logic [CSR_DATA_W-1:0] pick_center();
      case ($urandom_range(5))
         0:       return '0;
         1:       return CSR_DATA_W'(CENTER_MAX);
         default: return CSR_DATA_W'($urandom_range(CENTER_MAX));
      endcase
   endfunction

   function automatic logic [CSR_DATA_W-1:0] pick_radius();
      case ($urandom_range(19))
         0:       return '0;
         1:       return CSR_DATA_W'(1);
         2:       return CSR_DATA_W'(RADIUS_MAX);
         3:       return CSR_DATA_W'($urandom_range(CENTER_MAX));
         4, 5, 6: return CSR_DATA_W'($urandom_range(RADIUS_MAX, 13));
         default: return CSR_DATA_W'($urandom_range(12, 1));
      endcase
   endfunction

   task automatic test_random_traces(input int send_pct, input int recv_pct,
                                     input int items);
      int sent;
      int burst;
      sent          = 0;
      send_idle_pct = send_pct;
      recv_idle_pct = recv_pct;
      while (sent < items) begin
         if ($urandom_range(1)) write_register(CSR_CENTER_X, pick_center());
         if ($urandom_range(1)) write_register(CSR_CENTER_Y, pick_center());
         if ($urandom_range(2) != 0) write_register(CSR_RADIUS, pick_radius());
         burst = $urandom_range(60, 20);
         if (burst > items - sent) burst = items - sent;
         // half the bursts restart, the rest carry on from where the last left off
         send_step(1'($urandom_range(1)));
         repeat (burst - 1) send_step($urandom_range(99) < 4);
         sent += burst;
         drain_points();
      end
   endtask

   initial begin
      reset       = 1'b1;
      req_push    = 1'b0;
      req_restart = 1'b0;
      csr_wen     = 1'b0;
      csr_index   = CSR_CENTER_X;
      csr_wdata   = '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_idle_pct = 17;
      recv_idle_pct = 58;
      test_reset_trace();
      test_coordinate_extremes();
      test_full_lap();
      test_radius_rewrite();
      test_unmapped_index();

      test_random_traces(17, 58, 275);
      test_random_traces(58, 17, 275);
      test_random_traces(0, 0, 276);

      drain_points();
      if (error_count == 0) begin
         $display("[circle_trace_point_generator] OK");
      end else begin
         $display("[circle_trace_point_generator] ERROR");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
+incdir+src
src/ctpg_pkg.sv
src/ctpg_front.sv
src/ctpg_queue.sv
src/ctpg_back.sv
src/circle_trace_point_generator.sv
verif/circle_trace_point_generator_test.sv
